// ===== hw/rtl/rsst_pkg.sv =====
// Shared types and constants for the ray segment versus sphere test.
// Holds the beat payload structs and the reason codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsst_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int LEN_W   = COORD_W - 1;

    typedef enum logic [2:0] {
        RSN_START_IN = 3'd0,
        RSN_END_IN   = 3'd1,
        RSN_BEHIND   = 3'd2,
        RSN_BEYOND   = 3'd3,
        RSN_OUTSIDE  = 3'd4,
        RSN_CROSSES  = 3'd5
    } rsst_reason_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic        [LEN_W-1:0]   seg_length;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [LEN_W-1:0]   sphere_radius;
    } rsst_in_t;

    typedef struct packed {
        logic         hit;
        rsst_reason_t reason;
    } rsst_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsst_isqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Used by the ray segment versus sphere test; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rsst_isqrt #(
    parameter int STEPS = 32
) (
    input  wire logic                 aclk,
    input  wire logic [STEPS-1:0]     stage_en,
    input  wire logic [2*STEPS-1:0]   rad_in,
    output logic      [STEPS-1:0]     root_out
);

    localparam int W = 2 * STEPS;

    logic [W-1:0] rem_reg [STEPS-1];
    logic [W-1:0] res_reg [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * j);
        logic [W-1:0] rem_prev;
        logic [W-1:0] res_prev;
        logic [W-1:0] trial;
        logic         take;
        logic [W-1:0] res_next;

        if (j == 0) begin : g_first
            assign rem_prev = rad_in;
            assign res_prev = '0;
        end else begin : g_mid
            assign rem_prev = rem_reg[j-1];
            assign res_prev = res_reg[j-1];
        end

        assign trial    = res_prev + BIT;
        assign take     = (rem_prev >= trial);
        assign res_next = take ? ((res_prev >> 1) + BIT) : (res_prev >> 1);

        always_ff @(posedge aclk) begin
            if (stage_en[j]) begin
                res_reg[j] <= res_next;
            end
        end

        if (j < STEPS - 1) begin : g_rem
            logic [W-1:0] rem_next;
            assign rem_next = take ? (rem_prev - trial) : rem_prev;
            always_ff @(posedge aclk) begin
                if (stage_en[j]) begin
                    rem_reg[j] <= rem_next;
                end
            end
        end
    end

    assign root_out = res_reg[STEPS-1][STEPS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/rsst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the unit direction.
// Computes (dividend << (Q_W-1)) / divisor; a zero divisor gives a zero quotient.
`timescale 1ns / 1ps
`default_nettype none

module rsst_div #(
    parameter int DVD_W = 30,
    parameter int DVS_W = 31,
    parameter int Q_W   = 17
) (
    input  wire logic             aclk,
    input  wire logic [Q_W-1:0]   stage_en,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [Q_W-1:0]   quotient
);

    localparam int REM_W = DVS_W + Q_W;

    logic [REM_W-1:0] rem_reg [Q_W-1];
    logic [DVS_W-1:0] dvs_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int K = Q_W - 1 - j;
        logic [REM_W-1:0] rem_prev;
        logic [DVS_W-1:0] dvs_prev;
        logic [Q_W-1:0]   quo_prev;
        logic [REM_W-1:0] trial;
        logic             take;

        if (j == 0) begin : g_first
            assign rem_prev = REM_W'(dividend) << (Q_W - 1);
            assign dvs_prev = divisor;
            assign quo_prev = '0;
        end else begin : g_mid
            assign rem_prev = rem_reg[j-1];
            assign dvs_prev = dvs_reg[j-1];
            assign quo_prev = quo_reg[j-1];
        end

        assign trial = REM_W'(dvs_prev) << K;
        assign take  = (rem_prev >= trial);

        always_ff @(posedge aclk) begin
            if (stage_en[j]) begin
                dvs_reg[j] <= dvs_prev;
                quo_reg[j] <= {quo_prev[Q_W-2:0], take};
            end
        end

        if (j < Q_W - 1) begin : g_rem
            logic [REM_W-1:0] rem_next;
            assign rem_next = take ? (rem_prev - trial) : rem_prev;
            always_ff @(posedge aclk) begin
                if (stage_en[j]) begin
                    rem_reg[j] <= rem_next;
                end
            end
        end
    end

    assign quotient = quo_reg[Q_W-1] & {Q_W{|dvs_reg[Q_W-1]}};

endmodule

`default_nettype wire

// ===== hw/rtl/ray_segment_sphere_test.sv =====
// Top level of the ray segment versus sphere test pipeline.
// Depends on rsst_pkg, rsst_isqrt and rsst_div.
`timescale 1ns / 1ps
`default_nettype none

// Ray segment versus sphere test. Each input beat carries one segment (start,
// direction, length) and one sphere (center, radius) in signed Q16.16, and
// produces exactly one result beat with a hit flag and a reason code. The
// block is a fully pipelined datapath of 60 register stages: it accepts one
// beat every cycle while the result side does not stall, and each result beat
// is held in the output stage until the result side takes it. The depth
// comes from the 32-stage square root that normalizes the direction and the
// 17-stage divider per component that forms the unit vector; the remaining
// stages hold one multiplier or one wide add each. Every stage carries its own
// valid bit and ready ripples back stage by stage, so a stall on the result
// side fills empty stages first and the input keeps taking beats while any
// bubble is left. A zero direction yields a zero unit vector, so the end point
// equals the start and the projection is zero. Nothing saturates.

module ray_segment_sphere_test (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rsst_pkg::rsst_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rsst_pkg::rsst_out_t     m_data
);

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = rsst_pkg::FRAC_W + 1;
    localparam int DP_W       = 30;

    // Stage map.
    localparam int ST_IN      = 0;
    localparam int ST_MAG     = 1;
    localparam int ST_SQ      = 2;
    localparam int ST_SUM     = 3;
    localparam int ST_SQRT0   = 4;
    localparam int ST_DIV0    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV_END = ST_DIV0 + DIV_STEPS - 1;
    localparam int ST_U       = ST_DIV_END + 1;
    localparam int ST_PROD    = ST_U + 1;
    localparam int ST_DIFF    = ST_PROD + 1;
    localparam int ST_ABS     = ST_DIFF + 1;
    localparam int ST_SQE     = ST_ABS + 1;
    localparam int ST_ACC     = ST_SQE + 1;
    localparam int ST_OUT     = ST_ACC + 1;
    localparam int N_ST       = ST_OUT + 1;

    // Side data that travels alongside the square root and divider stages.
    typedef struct packed {
        logic signed [32:0] vec_x;
        logic signed [32:0] vec_y;
        logic signed [32:0] vec_z;
        logic [67:0]        dist2s;
        logic [61:0]        r2;
        logic [30:0]        len;
        logic [2:0]         dneg;
        logic [DP_W-1:0]    dp_x;
        logic [DP_W-1:0]    dp_y;
        logic [DP_W-1:0]    dp_z;
    } sb_t;

    // ------------------------------------------------------------------
    // Valid bits and the ready ripple.
    // ------------------------------------------------------------------
    logic [N_ST-1:0] vld_reg;
    logic [N_ST-1:0] vld_next;
    logic [N_ST-1:0] en;

    assign en[N_ST-1] = ~vld_reg[N_ST-1] | m_ready;
    for (genvar k = 0; k < N_ST - 1; k++) begin : g_en
        assign en[k] = ~vld_reg[k] | en[k+1];
    end

    assign vld_next = {vld_reg[N_ST-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < N_ST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_ready = en[ST_IN];
    assign m_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Input capture.
    // ------------------------------------------------------------------
    rsst_pkg::rsst_in_t in_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            in_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Magnitudes, direction prescale and center minus start.
    // ------------------------------------------------------------------
    logic [31:0]        dmag_x, dmag_y, dmag_z, dmax;
    logic [1:0]         sh;
    logic signed [32:0] vec_x_next, vec_y_next, vec_z_next;

    logic [DP_W-1:0]    dp1_reg [3];
    logic [2:0]         dneg1_reg;
    logic signed [32:0] vec1_reg [3];
    logic [32:0]        vm1_reg [3];
    logic [30:0]        len1_reg, rad1_reg;

    always_comb begin
        dmag_x = in_reg.dir_x[31] ? (~in_reg.dir_x + 32'd1) : in_reg.dir_x;
        dmag_y = in_reg.dir_y[31] ? (~in_reg.dir_y + 32'd1) : in_reg.dir_y;
        dmag_z = in_reg.dir_z[31] ? (~in_reg.dir_z + 32'd1) : in_reg.dir_z;
        dmax   = (dmag_x > dmag_y) ? dmag_x : dmag_y;
        if (dmag_z > dmax) begin
            dmax = dmag_z;
        end
        // Smallest shift that brings the largest magnitude below 2^30.
        if (dmax[31]) begin
            sh = 2'd2;
        end else if (dmax[30]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
        vec_x_next = 33'(in_reg.center_x) - 33'(in_reg.start_x);
        vec_y_next = 33'(in_reg.center_y) - 33'(in_reg.start_y);
        vec_z_next = 33'(in_reg.center_z) - 33'(in_reg.start_z);
    end

    function automatic logic [32:0] abs33(input logic signed [32:0] a);
        logic [32:0] r;
        r = a[32] ? (~a + 33'd1) : a;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (en[ST_MAG]) begin
            dp1_reg[0]  <= DP_W'(dmag_x >> sh);
            dp1_reg[1]  <= DP_W'(dmag_y >> sh);
            dp1_reg[2]  <= DP_W'(dmag_z >> sh);
            dneg1_reg   <= {in_reg.dir_z[31], in_reg.dir_y[31], in_reg.dir_x[31]};
            vec1_reg[0] <= vec_x_next;
            vec1_reg[1] <= vec_y_next;
            vec1_reg[2] <= vec_z_next;
            vm1_reg[0]  <= abs33(vec_x_next);
            vm1_reg[1]  <= abs33(vec_y_next);
            vm1_reg[2]  <= abs33(vec_z_next);
            len1_reg    <= in_reg.seg_length;
            rad1_reg    <= in_reg.sphere_radius;
        end
    end

    // ------------------------------------------------------------------
    // Squares.
    // ------------------------------------------------------------------
    logic [59:0]        dsq2_reg [3];
    logic [65:0]        vsq2_reg [3];
    logic [61:0]        r2_2_reg;
    logic [DP_W-1:0]    dp2_reg [3];
    logic [2:0]         dneg2_reg;
    logic signed [32:0] vec2_reg [3];
    logic [30:0]        len2_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_SQ]) begin
            for (int i = 0; i < 3; i++) begin
                dsq2_reg[i] <= 60'(dp1_reg[i]) * 60'(dp1_reg[i]);
                vsq2_reg[i] <= 66'(vm1_reg[i]) * 66'(vm1_reg[i]);
                dp2_reg[i]  <= dp1_reg[i];
                vec2_reg[i] <= vec1_reg[i];
            end
            r2_2_reg  <= 62'(rad1_reg) * 62'(rad1_reg);
            dneg2_reg <= dneg1_reg;
            len2_reg  <= len1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sums of squares; side data enters its carry line here.
    // ------------------------------------------------------------------
    logic [61:0] sumd_reg;
    sb_t         sb_reg [ST_SUM:ST_DIV_END];
    sb_t         sb_next;

    always_comb begin
        sb_next.vec_x  = vec2_reg[0];
        sb_next.vec_y  = vec2_reg[1];
        sb_next.vec_z  = vec2_reg[2];
        sb_next.dist2s = 68'(vsq2_reg[0]) + 68'(vsq2_reg[1]) + 68'(vsq2_reg[2]);
        sb_next.r2     = r2_2_reg;
        sb_next.len    = len2_reg;
        sb_next.dneg   = dneg2_reg;
        sb_next.dp_x   = dp2_reg[0];
        sb_next.dp_y   = dp2_reg[1];
        sb_next.dp_z   = dp2_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            sumd_reg       <= 62'(dsq2_reg[0]) + 62'(dsq2_reg[1]) + 62'(dsq2_reg[2]);
            sb_reg[ST_SUM] <= sb_next;
        end
    end

    for (genvar k = ST_SUM + 1; k <= ST_DIV_END; k++) begin : g_sb
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Direction norm and unit vector components.
    // ------------------------------------------------------------------
    logic [SQRT_STEPS-1:0] root;
    logic [DIV_STEPS-1:0]  quo [3];

    rsst_isqrt #(
        .STEPS (SQRT_STEPS)
    ) u_isqrt (
        .aclk     (aclk),
        .stage_en (en[ST_SQRT0 +: SQRT_STEPS]),
        .rad_in   ({2'b00, sumd_reg}),
        .root_out (root)
    );

    rsst_div #(
        .DVD_W (DP_W),
        .DVS_W (31),
        .Q_W   (DIV_STEPS)
    ) u_div_x (
        .aclk     (aclk),
        .stage_en (en[ST_DIV0 +: DIV_STEPS]),
        .dividend (sb_reg[ST_DIV0-1].dp_x),
        .divisor  (root[30:0]),
        .quotient (quo[0])
    );

    rsst_div #(
        .DVD_W (DP_W),
        .DVS_W (31),
        .Q_W   (DIV_STEPS)
    ) u_div_y (
        .aclk     (aclk),
        .stage_en (en[ST_DIV0 +: DIV_STEPS]),
        .dividend (sb_reg[ST_DIV0-1].dp_y),
        .divisor  (root[30:0]),
        .quotient (quo[1])
    );

    rsst_div #(
        .DVD_W (DP_W),
        .DVS_W (31),
        .Q_W   (DIV_STEPS)
    ) u_div_z (
        .aclk     (aclk),
        .stage_en (en[ST_DIV0 +: DIV_STEPS]),
        .dividend (sb_reg[ST_DIV0-1].dp_z),
        .divisor  (root[30:0]),
        .quotient (quo[2])
    );

    // ------------------------------------------------------------------
    // Signed unit vector.
    // ------------------------------------------------------------------
    logic signed [DIV_STEPS:0] u_reg [3];
    logic signed [32:0]        vecu_reg [3];
    logic [67:0]               dist2s_u_reg;
    logic [61:0]               r2_u_reg;
    logic [30:0]               len_u_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_U]) begin
            for (int i = 0; i < 3; i++) begin
                if (sb_reg[ST_DIV_END].dneg[i]) begin
                    u_reg[i] <= -$signed({1'b0, quo[i]});
                end else begin
                    u_reg[i] <= $signed({1'b0, quo[i]});
                end
            end
            vecu_reg[0]  <= sb_reg[ST_DIV_END].vec_x;
            vecu_reg[1]  <= sb_reg[ST_DIV_END].vec_y;
            vecu_reg[2]  <= sb_reg[ST_DIV_END].vec_z;
            dist2s_u_reg <= sb_reg[ST_DIV_END].dist2s;
            r2_u_reg     <= sb_reg[ST_DIV_END].r2;
            len_u_reg    <= sb_reg[ST_DIV_END].len;
        end
    end

    // ------------------------------------------------------------------
    // Products: length times u for the end point, v times u for m.
    // ------------------------------------------------------------------
    logic signed [49:0] prodl_reg [3];
    logic signed [50:0] prodv_reg [3];
    logic signed [32:0] vecp_reg [3];
    logic [67:0]        dist2s_p_reg;
    logic [61:0]        r2_p_reg;
    logic [30:0]        len_p_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_PROD]) begin
            for (int i = 0; i < 3; i++) begin
                prodl_reg[i] <= 50'($signed({1'b0, len_u_reg}) * u_reg[i]);
                prodv_reg[i] <= 51'(vecu_reg[i] * u_reg[i]);
                vecp_reg[i]  <= vecu_reg[i];
            end
            dist2s_p_reg <= dist2s_u_reg;
            r2_p_reg     <= r2_u_reg;
            len_p_reg    <= len_u_reg;
        end
    end

    // ------------------------------------------------------------------
    // End point minus center, and the dot product.
    // ------------------------------------------------------------------
    logic signed [34:0] diffe_reg [3];
    logic signed [52:0] dot_reg;
    logic [67:0]        dist2s_d_reg;
    logic [61:0]        r2_d_reg;
    logic [30:0]        len_d_reg;
    logic signed [33:0] delta [3];
    logic signed [34:0] diffe_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            delta[i]      = prodl_reg[i][49:16];
            diffe_next[i] = 35'(delta[i]) - 35'(vecp_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_DIFF]) begin
            for (int i = 0; i < 3; i++) begin
                diffe_reg[i] <= diffe_next[i];
            end
            dot_reg      <= 53'(prodv_reg[0]) + 53'(prodv_reg[1]) + 53'(prodv_reg[2]);
            dist2s_d_reg <= dist2s_p_reg;
            r2_d_reg     <= r2_p_reg;
            len_d_reg    <= len_p_reg;
        end
    end

    // ------------------------------------------------------------------
    // Magnitudes of the end point offset; m is the dot product scaled down.
    // ------------------------------------------------------------------
    logic [32:0]        demag_reg [3];
    logic signed [36:0] m_reg;
    logic [67:0]        dist2s_a_reg;
    logic [61:0]        r2_a_reg;
    logic [30:0]        len_a_reg;
    logic [34:0]        deabs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            deabs[i] = diffe_reg[i][34] ? (~diffe_reg[i] + 35'd1) : diffe_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_ABS]) begin
            for (int i = 0; i < 3; i++) begin
                demag_reg[i] <= deabs[i][32:0];
            end
            m_reg        <= dot_reg[52:16];
            dist2s_a_reg <= dist2s_d_reg;
            r2_a_reg     <= r2_d_reg;
            len_a_reg    <= len_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Squares of the end offset, m squared and the projection range checks.
    // ------------------------------------------------------------------
    logic [65:0] sqe_reg [3];
    logic [61:0] m2_reg;
    logic        mneg_s_reg, mgt_s_reg;
    logic [67:0] dist2s_s_reg;
    logic [61:0] r2_s_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_SQE]) begin
            for (int i = 0; i < 3; i++) begin
                sqe_reg[i] <= 66'(demag_reg[i]) * 66'(demag_reg[i]);
            end
            // Only meaningful when 0 <= m <= length, which fits in 31 bits.
            m2_reg       <= 62'(m_reg[30:0]) * 62'(m_reg[30:0]);
            mneg_s_reg   <= m_reg[36];
            mgt_s_reg    <= (m_reg > $signed({6'b000000, len_a_reg}));
            dist2s_s_reg <= dist2s_a_reg;
            r2_s_reg     <= r2_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // End point distance and radius squared plus m squared.
    // ------------------------------------------------------------------
    logic [67:0] dist2e_reg;
    logic [62:0] rm_reg;
    logic        mneg_c_reg, mgt_c_reg;
    logic [67:0] dist2s_c_reg;
    logic [61:0] r2_c_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_ACC]) begin
            dist2e_reg   <= 68'(sqe_reg[0]) + 68'(sqe_reg[1]) + 68'(sqe_reg[2]);
            rm_reg       <= 63'(r2_s_reg) + 63'(m2_reg);
            mneg_c_reg   <= mneg_s_reg;
            mgt_c_reg    <= mgt_s_reg;
            dist2s_c_reg <= dist2s_s_reg;
            r2_c_reg     <= r2_s_reg;
        end
    end

    // ------------------------------------------------------------------
    // Decision and output register.
    // ------------------------------------------------------------------
    rsst_pkg::rsst_reason_t reason_next;
    rsst_pkg::rsst_out_t    out_reg;

    always_comb begin
        if (dist2s_c_reg < 68'(r2_c_reg)) begin
            reason_next = rsst_pkg::RSN_START_IN;
        end else if (dist2e_reg < 68'(r2_c_reg)) begin
            reason_next = rsst_pkg::RSN_END_IN;
        end else if (mneg_c_reg) begin
            reason_next = rsst_pkg::RSN_BEHIND;
        end else if (mgt_c_reg) begin
            reason_next = rsst_pkg::RSN_BEYOND;
        end else if (68'(rm_reg) < dist2s_c_reg) begin
            reason_next = rsst_pkg::RSN_OUTSIDE;
        end else begin
            reason_next = rsst_pkg::RSN_CROSSES;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            out_reg.reason <= reason_next;
            out_reg.hit    <= (reason_next == rsst_pkg::RSN_START_IN) ||
                              (reason_next == rsst_pkg::RSN_END_IN) ||
                              (reason_next == rsst_pkg::RSN_CROSSES);
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ===== sim/rsst_scoreboard.sv =====
// Scoreboard for the ray segment versus sphere test: watches both channels,
// predicts each result from the accepted input beat and compares in order.
// Depends on rsst_pkg for the beat payload structs and reason codes.
`timescale 1ns / 1ps
`default_nettype none

module rsst_scoreboard (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire rsst_pkg::rsst_in_t  s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire rsst_pkg::rsst_out_t m_data,
    output int                       fail_count,
    output int                       pending
);

    typedef logic signed [127:0] wide_t;

    rsst_pkg::rsst_out_t expected_results[$];
    int                  mismatches;

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic rsst_pkg::rsst_out_t classify_segment(rsst_pkg::rsst_in_t b);
        longint                 st[3], dr[3], ce[3], u[3], en[3];
        longint unsigned        mg[3];
        longint unsigned        big, s, n;
        int                     sh;
        wide_t                  len, rad, r2, d_start, d_end, dot, m, diff;
        rsst_pkg::rsst_reason_t rsn;
        rsst_pkg::rsst_out_t    r;
        st[0] = b.start_x;  st[1] = b.start_y;  st[2] = b.start_z;
        dr[0] = b.dir_x;    dr[1] = b.dir_y;    dr[2] = b.dir_z;
        ce[0] = b.center_x; ce[1] = b.center_y; ce[2] = b.center_z;
        len = wide_t'(b.seg_length);
        rad = wide_t'(b.sphere_radius);

        // Normalize: scale the magnitudes below 2^30, integer root, divide.
        for (int i = 0; i < 3; i++) mg[i] = (dr[i] < 0) ? -dr[i] : dr[i];
        big = mg[0] > mg[1] ? mg[0] : mg[1];
        if (mg[2] > big) big = mg[2];
        sh = 0;
        while (sh < 63 && (big >> sh) >= (64'd1 << 30)) sh++;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = mg[i] >> sh;
            s = s + mg[i] * mg[i];
        end
        n = root_floor(s);
        for (int i = 0; i < 3; i++) begin
            longint q;
            q = (n != 0) ? longint'((mg[i] << rsst_pkg::FRAC_W) / n) : 0;
            u[i] = (dr[i] < 0) ? -q : q;
        end

        for (int i = 0; i < 3; i++)
            en[i] = st[i] + longint'((len * wide_t'(u[i])) >>> rsst_pkg::FRAC_W);
        r2 = rad * rad;
        d_start = 0;
        d_end   = 0;
        dot     = 0;
        for (int i = 0; i < 3; i++) begin
            diff    = wide_t'(ce[i]) - wide_t'(st[i]);
            d_start = d_start + diff * diff;
            dot     = dot + diff * wide_t'(u[i]);
            diff    = wide_t'(ce[i]) - wide_t'(en[i]);
            d_end   = d_end + diff * diff;
        end
        m = dot >>> rsst_pkg::FRAC_W;

        if (d_start < r2)                rsn = rsst_pkg::RSN_START_IN;
        else if (d_end < r2)             rsn = rsst_pkg::RSN_END_IN;
        else if (m < 0)                  rsn = rsst_pkg::RSN_BEHIND;
        else if (m > len)                rsn = rsst_pkg::RSN_BEYOND;
        else if (r2 + m * m < d_start)   rsn = rsst_pkg::RSN_OUTSIDE;
        else                             rsn = rsst_pkg::RSN_CROSSES;
        r.reason = rsn;
        r.hit    = (rsn == rsst_pkg::RSN_START_IN || rsn == rsst_pkg::RSN_END_IN ||
                    rsn == rsst_pkg::RSN_CROSSES);
        return r;
    endfunction

    initial begin
        fail_count = 0;
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        rsst_pkg::rsst_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(classify_segment(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (mismatches < 10)
                        $display("%0t: result beat with nothing expected: hit=%0b reason=%0d",
                                 $realtime, m_data.hit, m_data.reason);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.hit !== m_data.hit || want.reason !== m_data.reason) begin
                        fail_count <= fail_count + 1;
                        if (mismatches < 10)
                            $display({"%0t: mismatch: expected hit=%0b reason=%0d, ",
                                      "got hit=%0b reason=%0d"},
                                     $realtime, want.hit, want.reason, m_data.hit,
                                     m_data.reason);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb_ray_segment_sphere_test.sv =====
// Testbench top for the ray segment versus sphere test: clock, reset, stimulus
// and the verdict. Depends on rsst_pkg, the block and rsst_scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module tb_ray_segment_sphere_test;

    localparam int ONE = 32'h0001_0000;   // 1.0 in Q16.16
    localparam int RANDOM_BEATS = 1200;
    localparam int DRAIN_CYCLES = 80;     // a bit more than the 60-stage pipeline

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    rsst_pkg::rsst_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    rsst_pkg::rsst_out_t m_data;
    int                  fail_count;
    int                  pending;
    int                  beats_sent;
    bit                  stall_done;

    ray_segment_sphere_test dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rsst_scoreboard scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Safety net: the slowest correct run is well under a tenth of this.
    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic rsst_pkg::rsst_in_t make_segment(int sx, int sy, int sz,
                                                        int dx, int dy, int dz, int len,
                                                        int cx, int cy, int cz, int rad);
        rsst_pkg::rsst_in_t b;
        b.start_x  = sx;  b.start_y  = sy;  b.start_z  = sz;
        b.dir_x    = dx;  b.dir_y    = dy;  b.dir_z    = dz;
        b.seg_length = len[rsst_pkg::LEN_W-1:0];
        b.center_x = cx;  b.center_y = cy;  b.center_z = cz;
        b.sphere_radius = rad[rsst_pkg::LEN_W-1:0];
        return b;
    endfunction

    function automatic int signed_range(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Most random beats are real geometry around a sphere so every reason
    // code shows up often; the rest are raw bits to toggle every field bit.
    function automatic rsst_pkg::rsst_in_t random_segment();
        rsst_pkg::rsst_in_t b;
        logic [11*32-1:0]   raw;
        int                 cx, cy, cz, sx, sy, sz, span, rad, len;
        int                 pick;
        pick = $urandom_range(9);
        if (pick < 2) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom};
            b = raw[$bits(rsst_pkg::rsst_in_t)-1:0];
            return b;
        end
        span = (pick == 2) ? 32'h3fff_ffff : (ONE << $urandom_range(4, 12));
        cx = signed_range(span);
        cy = signed_range(span);
        cz = signed_range(span);
        rad = $urandom_range(span / 2);
        sx = cx + signed_range(span / 2);
        sy = cy + signed_range(span / 2);
        sz = cz + signed_range(span / 2);
        len = $urandom_range(span);
        if ($urandom_range(2) != 0) begin
            // Aim roughly at the center so crossings and near misses happen.
            b = make_segment(sx, sy, sz,
                             (cx - sx) + signed_range(span / 8),
                             (cy - sy) + signed_range(span / 8),
                             (cz - sz) + signed_range(span / 8),
                             len, cx, cy, cz, rad);
        end else begin
            b = make_segment(sx, sy, sz, signed_range(span), signed_range(span),
                             signed_range(span), len, cx, cy, cz, rad);
        end
        return b;
    endfunction

    // Offer one beat and hold it until the block takes it. The valid line is
    // only ever assigned once per falling edge.
    task automatic send_beat(rsst_pkg::rsst_in_t b);
        s_data  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Receiver: one long hold-off early on so the pipeline fills and pushes
    // back on the input, then alternating stretches of full speed and random
    // stalls of two different densities.
    initial begin
        int phase;
        m_ready    = 1'b0;
        stall_done = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        m_ready <= 1'b1;
        while (beats_sent < 60) @(negedge aclk);
        m_ready <= 1'b0;
        repeat (250) @(negedge aclk);
        stall_done = 1'b1;
        forever begin
            phase = $urandom_range(2);
            repeat ($urandom_range(20, 120)) begin
                case (phase)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(3) != 0);
                    default: m_ready <= (($urandom_range(5) % 3) != 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    initial begin
        rsst_pkg::rsst_in_t directed[$];
        int                 burst;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        beats_sent = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Start inside, end inside, behind, beyond, passing outside, crossing.
        directed.push_back(make_segment(0, 0, 0, ONE, 0, 0, 4*ONE, 0, 0, 0, ONE));
        directed.push_back(make_segment(0, 0, 0, ONE, 0, 0, 4*ONE, 4*ONE, 0, 0, ONE));
        directed.push_back(make_segment(0, 0, 0, ONE, 0, 0, 4*ONE, -5*ONE, 0, 0, ONE));
        directed.push_back(make_segment(0, 0, 0, ONE, 0, 0, 4*ONE, 9*ONE, 0, 0, ONE));
        directed.push_back(make_segment(0, 0, 0, ONE, 0, 0, 9*ONE, 4*ONE, 3*ONE, 0, ONE));
        directed.push_back(make_segment(0, 0, 0, 0, ONE, 0, 9*ONE, 0, 4*ONE, 0, ONE/2));
        // Zero direction: the end point equals the start.
        directed.push_back(make_segment(ONE, ONE, ONE, 0, 0, 0, 8*ONE, 0, 0, 0, ONE));
        directed.push_back(make_segment(ONE, 0, 0, 0, 0, 0, 8*ONE, 0, 0, 0, 2*ONE));
        // Zero radius: segments through the center; nothing is inside.
        directed.push_back(make_segment(0, 0, 0, ONE, ONE, ONE, 8*ONE, 2*ONE, 2*ONE, 2*ONE, 0));
        directed.push_back(make_segment(0, 0, 0, 0, 0, ONE, 8*ONE, 0, 0, 0, 0));
        // Zero length and diagonal direction.
        directed.push_back(make_segment(0, 0, 0, -ONE, ONE, -ONE, 0, ONE, 0, 0, ONE/4));
        // Field extremes.
        directed.push_back(make_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h7fff_ffff));
        directed.push_back(make_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 0));
        directed.push_back(make_segment(32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 1, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff));
        directed.push_back(make_segment(0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_segment(-1, -1, -1, -1, -1, -1, 32'h7fff_ffff, -1, -1, -1, 0));
        foreach (directed[i]) send_beat(directed[i]);

        // Pause until every expected result is back.
        wait_for_drain();

        for (int n = 0; n < RANDOM_BEATS; n += burst) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) send_beat(random_segment());
            if ($urandom_range(3) == 0) idle_sender($urandom_range(1, 15));
            if (n > RANDOM_BEATS / 2 && n < RANDOM_BEATS / 2 + 40) wait_for_drain();
        end
        s_valid <= 1'b0;

        while (pending != 0 || !stall_done) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
